[hdl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, byte codes and result codes of the bracket subscript
// classifier.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// Default limits for the top-level parameters.
	localparam int MAX_LEN_DEF   = 1024;
	localparam int MAX_DEPTH_DEF = 15;

	// Field widths of the channels.
	localparam int CH_W     = 8;
	localparam int OFFSET_W = 10;
	localparam int TYPE_W   = 2;

	// Byte codes that the scanner reacts to.
	localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;

	// Status codes.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// Identifier type codes.
	localparam logic [TYPE_W-1:0] ID_NONE    = 2'd0;
	localparam logic [TYPE_W-1:0] ID_NUMERIC = 2'd1;
	localparam logic [TYPE_W-1:0] ID_PATH    = 2'd2;

	// One result item.
	typedef struct packed {
		logic                status;
		logic [TYPE_W-1:0]   id_type;
		logic [OFFSET_W-1:0] start_pos;
		logic [OFFSET_W-1:0] end_pos;
	} result_t;

endpackage

[hdl/bsc_text_if.sv]
// ----------------------------------------------------------------------------
// bsc_text_if
// Byte channel into the classifier: a first-byte flag and the raw byte.
// ----------------------------------------------------------------------------
interface bsc_text_if;

	logic                    valid;
	logic                    ready;
	logic                    first;
	logic [bsc_pkg::CH_W-1:0] ch;

	modport source (output valid, output first, output ch, input ready);
	modport sink (input valid, input first, input ch, output ready);

endinterface

[hdl/bsc_result_if.sv]
// ----------------------------------------------------------------------------
// bsc_result_if
// Result channel out of the classifier: status, type and the two offsets.
// ----------------------------------------------------------------------------
interface bsc_result_if;

	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [bsc_pkg::TYPE_W-1:0]   id_type;
	logic [bsc_pkg::OFFSET_W-1:0] start_pos;
	logic [bsc_pkg::OFFSET_W-1:0] end_pos;

	modport source (output valid, output status, output id_type, output start_pos,
		output end_pos, input ready);
	modport sink (input valid, input status, input id_type, input start_pos,
		input end_pos, output ready);

endinterface

[hdl/bracket_subscript_classifier.sv]
// ----------------------------------------------------------------------------
// bracket_subscript_classifier
// Classifies the text of a bracket subscript as a number, a dotted
// identifier path or invalid, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one byte item in every clock cycle while text.ready is
// high. Each byte updates the scan state in the same cycle it is accepted,
// and a byte that ends a scan (a top-level ']', a zero byte, a double dot,
// too long a string or too deep a nesting) places its single result in the
// output register, or in the skid register behind it while the output
// register holds a result that is not taken, so bytes keep flowing while a
// result waits; text.ready drops only while both registers hold results.
// Bytes outside a scan are dropped until the next byte marked first.
module bracket_subscript_classifier #(
	parameter int MAX_LEN   = bsc_pkg::MAX_LEN_DEF,
	parameter int MAX_DEPTH = bsc_pkg::MAX_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	bsc_text_if.sink            text,
	bsc_result_if.source        result
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int OFF_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 2);
	localparam int DEP_W = $clog2(MAX_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_DONE,
		PH_SKIP,
		PH_SCAN
	} phase_t;

	typedef enum logic [2:0] {
		CL_NONE,
		CL_DIGIT,
		CL_SPACE,
		CL_DOT,
		CL_OTHER
	} class_t;

	// Scan state.
	phase_t             phase_q;
	logic [POS_W-1:0]   pos_q;
	logic [OFF_W-1:0]   start_q;
	logic [OFF_W-1:0]   word_start_q;
	logic [OFF_W-1:0]   last_pos_q;
	logic               last_valid_q;
	logic [DEP_W-1:0]   depth_q;
	class_t             class_q;
	logic [1:0]         runs_q;
	logic [CNT_W-1:0]   words_q;
	logic [CNT_W-1:0]   dots_q;
	logic               other_q;
	logic               name_q;

	// Next scan state and the result of the current byte.
	phase_t             phase_d;
	logic [POS_W-1:0]   pos_d;
	logic [OFF_W-1:0]   start_d;
	logic [OFF_W-1:0]   word_start_d;
	logic [OFF_W-1:0]   last_pos_d;
	logic               last_valid_d;
	logic [DEP_W-1:0]   depth_d;
	class_t             class_d;
	logic [1:0]         runs_d;
	logic [CNT_W-1:0]   words_d;
	logic [CNT_W-1:0]   dots_d;
	logic               other_d;
	logic               name_d;
	logic               res_valid;
	bsc_pkg::result_t   res;

	// Output and skid registers.
	logic               out_valid_q;
	bsc_pkg::result_t   out_q;
	logic               skid_valid_q;
	bsc_pkg::result_t   skid_q;

	logic               accept;
	logic               pop;

	assign text.ready = !skid_valid_q;
	assign accept     = text.valid && text.ready;
	assign pop        = out_valid_q && result.ready;

	// Byte step: a first byte restarts the state, then the byte is decoded.
	always_comb begin
		logic [bsc_pkg::CH_W-1:0] c;
		logic [POS_W-1:0]   p;
		logic [OFF_W-1:0]   p_off;
		logic               finish;
		logic               finish_ok;
		logic [bsc_pkg::TYPE_W-1:0] fin_type;
		logic               is_digit;

		c         = text.ch;
		p         = '0;
		p_off     = '0;
		finish    = 1'b0;
		finish_ok = 1'b0;
		fin_type  = bsc_pkg::ID_NONE;
		is_digit  = (c >= bsc_pkg::CH_ZERO) && (c <= bsc_pkg::CH_NINE);

		if (text.first) begin
			phase_d      = PH_SKIP;
			pos_d        = '0;
			start_d      = '0;
			word_start_d = '0;
			last_pos_d   = '0;
			last_valid_d = 1'b0;
			depth_d      = '0;
			class_d      = CL_NONE;
			runs_d       = 2'd0;
			words_d      = CNT_W'(1);
			dots_d       = '0;
			other_d      = 1'b0;
			name_d       = 1'b1;
		end else begin
			phase_d      = phase_q;
			pos_d        = pos_q;
			start_d      = start_q;
			word_start_d = word_start_q;
			last_pos_d   = last_pos_q;
			last_valid_d = last_valid_q;
			depth_d      = depth_q;
			class_d      = class_q;
			runs_d       = runs_q;
			words_d      = words_q;
			dots_d       = dots_q;
			other_d      = other_q;
			name_d       = name_q;
		end

		if (phase_d != PH_DONE) begin
			p     = pos_d;
			p_off = p[OFF_W-1:0];
			if (p == POS_W'(MAX_LEN)) begin
				// The string ran past its length limit.
				finish = 1'b1;
			end else begin
				pos_d = p + 1'b1;
				if (!(phase_d == PH_SKIP && c == bsc_pkg::CH_SPACE)) begin
					// The first non-space byte fixes the start offset.
					if (phase_d == PH_SKIP) begin
						phase_d      = PH_SCAN;
						start_d      = p_off;
						word_start_d = p_off;
					end

					if (c == bsc_pkg::CH_NUL) begin
						finish = 1'b1;
					end else if (c == bsc_pkg::CH_LBRACK) begin
						if (depth_d == DEP_W'(MAX_DEPTH)) begin
							finish = 1'b1;
						end else begin
							depth_d = depth_d + 1'b1;
						end
					end else if (c == bsc_pkg::CH_RBRACK) begin
						if (depth_d == '0) begin
							// Closing bracket of the subscript: classify.
							finish = 1'b1;
							if (!last_valid_d) begin
								finish_ok = 1'b0;
							end else if (runs_d == 2'd1 && words_d == CNT_W'(1)
								&& !other_d) begin
								finish_ok = 1'b1;
								fin_type  = bsc_pkg::ID_NUMERIC;
							end else if (name_d && ((CNT_W + 1)'(dots_d) + 1'b1
								== (CNT_W + 1)'(words_d))) begin
								finish_ok = 1'b1;
								fin_type  = bsc_pkg::ID_PATH;
							end
						end else begin
							depth_d      = depth_d - 1'b1;
							last_pos_d   = p_off;
							last_valid_d = 1'b1;
						end
					end else if (depth_d == '0) begin
						// Top-level byte: track words, digit runs and dots.
						if ((class_d == CL_SPACE || class_d == CL_DOT)
							&& c != bsc_pkg::CH_SPACE) begin
							word_start_d = p_off;
						end
						if (c != bsc_pkg::CH_SPACE) begin
							last_pos_d   = p_off;
							last_valid_d = 1'b1;
						end

						if (is_digit) begin
							if (p_off == word_start_d) begin
								name_d = 1'b0;
							end
							if (class_d != CL_DIGIT) begin
								class_d = CL_DIGIT;
								if (runs_d != 2'd2) begin
									runs_d = runs_d + 1'b1;
								end
							end
						end else if (c == bsc_pkg::CH_SPACE) begin
							class_d = CL_SPACE;
						end else if (c == bsc_pkg::CH_DOT) begin
							if (class_d == CL_DOT) begin
								finish = 1'b1;
							end else begin
								class_d = CL_DOT;
								dots_d  = dots_d + 1'b1;
							end
						end else begin
							if (class_d == CL_SPACE || class_d == CL_DOT) begin
								words_d = words_d + 1'b1;
							end
							class_d = CL_OTHER;
							other_d = 1'b1;
						end
					end
				end
			end
		end

		if (finish) begin
			phase_d = PH_DONE;
		end

		// Result fields; an invalid result carries no type and no end offset.
		res_valid     = finish;
		res.status    = finish_ok ? bsc_pkg::STATUS_OK : bsc_pkg::STATUS_INVALID;
		res.id_type   = finish_ok ? fin_type : bsc_pkg::ID_NONE;
		res.start_pos = bsc_pkg::OFFSET_W'(start_d);
		res.end_pos   = finish_ok ? bsc_pkg::OFFSET_W'(last_pos_d) : '0;
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DONE;
			pos_q        <= '0;
			start_q      <= '0;
			word_start_q <= '0;
			last_pos_q   <= '0;
			last_valid_q <= 1'b0;
			depth_q      <= '0;
			class_q      <= CL_NONE;
			runs_q       <= 2'd0;
			words_q      <= CNT_W'(1);
			dots_q       <= '0;
			other_q      <= 1'b0;
			name_q       <= 1'b1;
		end else if (accept) begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			start_q      <= start_d;
			word_start_q <= word_start_d;
			last_pos_q   <= last_pos_d;
			last_valid_q <= last_valid_d;
			depth_q      <= depth_d;
			class_q      <= class_d;
			runs_q       <= runs_d;
			words_q      <= words_d;
			dots_q       <= dots_d;
			other_q      <= other_d;
			name_q       <= name_d;
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept && res_valid;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= accept && res_valid;
			end else if (accept && res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Result payloads follow the same moves as the valid flags.
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if (pop || !out_valid_q) begin
			out_q <= res;
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = out_q.status;
	assign result.id_type   = out_q.id_type;
	assign result.start_pos = out_q.start_pos;
	assign result.end_pos   = out_q.end_pos;

endmodule
